// File: hw/rtl/ppd_pkg.sv
// ----------------------------------------------------------------------------
// ppd_pkg
// Shared types, constants and helpers for the pinhole projection pipeline.
// ----------------------------------------------------------------------------
package ppd_pkg;

  // internal fixed point word, 30 fraction bits
  typedef logic signed [63:0] fx_t;

  // clamp bound of every internal product and sum
  localparam fx_t LIM     = 64'sh3FFF_FFFF_FFFF_FFFF;
  localparam fx_t NEG_LIM = -64'sh3FFF_FFFF_FFFF_FFFF;
  // one in the internal format
  localparam fx_t ONE_Q30 = 64'sh0000_0000_4000_0000;

  // multiplier latency in cycles
  localparam int unsigned MUL_LAT = 3;

  // divider: quotient width and quotient bits resolved per stage
  localparam int unsigned QUO_W      = 62;
  localparam int unsigned DIV_BITS   = 2;
  localparam int unsigned DIV_STAGES = QUO_W / DIV_BITS;

  // register stages after the divider, not counting the output register
  localparam int unsigned BACK_STAGES = 6 * MUL_LAT + 5;
  // cycles from the accepting edge to the edge that samples the result strobe
  localparam int unsigned LATENCY = DIV_STAGES + BACK_STAGES + 2;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_FOCAL_X   = 3'd0,
    CFG_FOCAL_Y   = 3'd1,
    CFG_PRINCIPAL = 3'd2,
    CFG_K1        = 3'd3,
    CFG_K2        = 3'd4,
    CFG_K3        = 3'd5,
    CFG_P1        = 3'd6,
    CFG_P2        = 3'd7
  } cfg_idx_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_ZERO_DEPTH = 2'd1,
    ST_SATURATED  = 2'd2
  } status_e;

  // saturating sum with overflow flag
  typedef struct packed {
    fx_t  val;
    logic ov;
  } sat_t;

  function automatic sat_t sat_add(fx_t a, fx_t b);
    fx_t  s;
    sat_t r;
    s     = a + b;
    r.val = s;
    r.ov  = 1'b0;
    if (s > LIM) begin
      r.val = LIM;
      r.ov  = 1'b1;
    end else if (s < NEG_LIM) begin
      r.val = NEG_LIM;
      r.ov  = 1'b1;
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/pinhole_projection_with_distortion.sv
// ----------------------------------------------------------------------------
// pinhole_projection_with_distortion
// Projects camera-frame points to pixels with radial and tangential lens
// distortion, one point per cycle through a fixed-latency pipeline.
// ----------------------------------------------------------------------------
//  channel   handshake                  payload
//  point     start / busy               point_x_i, point_y_i, point_z_i
//  result    done_o strobe              pixel_u_o, pixel_v_o, status_o
//  config    cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
//  One point is accepted every cycle; busy stays low.
//  From the accepting edge, a point passes through 31 divider stages
//  resolving two quotient bits each, then 24 stages for the sign, the
//  multiplies, the saturating adds and the result register.
//  Reset clears valid bits and loads the configuration reset values.
//  The result is shown for one cycle with done_o and cannot be held off.
// ----------------------------------------------------------------------------
module pinhole_projection_with_distortion (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] point_x_i,
  input  logic signed [31:0] point_y_i,
  input  logic signed [31:0] point_z_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [63:0]        cfg_data_i,
  output logic               done_o,
  output logic signed [31:0] pixel_u_o,
  output logic signed [31:0] pixel_v_o,
  output logic [1:0]         status_o
);
  import ppd_pkg::*;

  // stage of each value after the divider
  localparam int unsigned S_XX  = MUL_LAT;
  localparam int unsigned S_R2  = S_XX + 1;
  localparam int unsigned S_TX  = S_R2 + 1;
  localparam int unsigned S_PXY = S_XX + MUL_LAT;
  localparam int unsigned S_XYT = S_PXY + 1;
  localparam int unsigned S_R4  = S_R2 + MUL_LAT;
  localparam int unsigned S_PT  = S_TX + MUL_LAT;
  localparam int unsigned S_D1  = S_R4 + 1;
  localparam int unsigned S_R6  = S_R4 + MUL_LAT;
  localparam int unsigned S_D2  = S_R6 + 1;
  localparam int unsigned S_K3  = S_R6 + MUL_LAT;
  localparam int unsigned S_D   = S_K3 + 1;
  localparam int unsigned S_ND  = S_D + MUL_LAT;
  localparam int unsigned S_E1  = S_ND + 1;
  localparam int unsigned S_E2  = S_E1 + 1;
  localparam int unsigned S_UV  = S_E2 + MUL_LAT;

  // delay line lengths
  localparam int unsigned DL_R2   = S_R4 - S_R2;
  localparam int unsigned DL_XN   = S_D;
  localparam int unsigned DL_D1   = S_R6 - S_D1;
  localparam int unsigned DL_D2   = S_K3 - S_D2;
  localparam int unsigned DL_XYT1 = S_ND - S_XYT;
  localparam int unsigned DL_P1TY = S_ND - S_PT;
  localparam int unsigned DL_P2TX = S_E1 - S_PT;
  localparam int unsigned DL_XYT2 = S_E1 - S_XYT;

  typedef struct packed {
    logic [31:0]      rem;
    logic [QUO_W-1:0] nq;
  } div_lane_t;

  typedef struct packed {
    div_lane_t   lx;
    div_lane_t   ly;
    logic [31:0] dsr;
    logic        nx;
    logic        ny;
    logic        zd;
  } div_stage_t;

  // restoring division, DIV_BITS quotient bits per call
  function automatic div_lane_t div_step(div_lane_t l, logic [31:0] dsr);
    div_lane_t   o;
    logic [32:0] r;
    logic        qb;
    o = l;
    for (int b = 0; b < DIV_BITS; b++) begin
      r  = {o.rem, o.nq[QUO_W-1]};
      qb = (r >= {1'b0, dsr});
      if (qb) begin
        r = r - {1'b0, dsr};
      end
      o.rem = r[31:0];
      o.nq  = {o.nq[QUO_W-2:0], qb};
    end
    return o;
  endfunction

  // configuration registers
  logic [31:0]        focal_x_q, focal_y_q;
  logic [63:0]        pp_q;
  logic signed [31:0] k1_q, k2_q, k3_q, p1_q, p2_q;
  fx_t                k1, k2, k3, p1, p2, fxe, fye;

  // front end and divider
  logic        accept;
  logic [31:0] ax, ay, az;
  div_stage_t  dv_q [DIV_STAGES+1];
  logic        fv_q [DIV_STAGES+1];
  fx_t         qx, qy;

  // back end
  logic        vld_q [S_UV+1];
  logic        zd_q  [S_UV+1];
  logic        ov_q  [S_UV+1];
  logic [S_UV:0] hit;
  fx_t         xn_q, yn_q;

  fx_t  xx_p, yy_p, xy_p, p1xy_p, p2xy_p, r4_p, k1r2_p, p2tx_p, p1ty_p;
  fx_t  r6_p, k2r4_p, k3r6_p, xnd_p, ynd_p, u_p, v_p;
  logic xx_ov, yy_ov, xy_ov, p1xy_ov, p2xy_ov, r4_ov, k1r2_ov, p2tx_ov, p1ty_ov;
  logic r6_ov, k2r4_ov, k3r6_ov, xnd_ov, ynd_ov, u_ov, v_ov;

  sat_t r2_s, xx2_s, yy2_s, tx_s, ty_s, xyt1_s, xyt2_s, d1_s, d2_s, d_s;
  sat_t xe1_s, ye1_s, xd_s, yd_s;
  fx_t  r2_q, xx2_q, yy2_q, tx_q, ty_q, xyt1_q, xyt2_q, d1_q, d2_q, d_q;
  fx_t  xe1_q, ye1_q, xd_q, yd_q;

  fx_t r2_dl_q   [DL_R2];
  fx_t xn_dl_q   [DL_XN];
  fx_t yn_dl_q   [DL_XN];
  fx_t d1_dl_q   [DL_D1];
  fx_t d2_dl_q   [DL_D2];
  fx_t xyt1_dl_q [DL_XYT1];
  fx_t p1ty_dl_q [DL_P1TY];
  fx_t p2tx_dl_q [DL_P2TX];
  fx_t xyt2_dl_q [DL_XYT2];

  // output
  fx_t                pu, pv;
  logic               ovu, ovv, ov_fin;
  logic signed [31:0] pu_sat, pv_sat;
  logic               done_q;
  logic signed [31:0] pixel_u_q, pixel_v_q;
  status_e            status_q;

  // the pipeline never stalls
  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_x_q <= 32'd65536;
      focal_y_q <= 32'd65536;
      pp_q      <= '0;
      k1_q      <= '0;
      k2_q      <= '0;
      k3_q      <= '0;
      p1_q      <= '0;
      p2_q      <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_FOCAL_X:   focal_x_q <= cfg_data_i[31:0];
        CFG_FOCAL_Y:   focal_y_q <= cfg_data_i[31:0];
        CFG_PRINCIPAL: pp_q      <= cfg_data_i;
        CFG_K1:        k1_q      <= cfg_data_i[31:0];
        CFG_K2:        k2_q      <= cfg_data_i[31:0];
        CFG_K3:        k3_q      <= cfg_data_i[31:0];
        CFG_P1:        p1_q      <= cfg_data_i[31:0];
        CFG_P2:        p2_q      <= cfg_data_i[31:0];
      endcase
    end
  end

  assign k1  = fx_t'(k1_q);
  assign k2  = fx_t'(k2_q);
  assign k3  = fx_t'(k3_q);
  assign p1  = fx_t'(p1_q);
  assign p2  = fx_t'(p2_q);
  assign fxe = fx_t'({32'd0, focal_x_q});
  assign fye = fx_t'({32'd0, focal_y_q});

  // input magnitudes
  assign ax = point_x_i[31] ? (~point_x_i + 32'd1) : point_x_i;
  assign ay = point_y_i[31] ? (~point_y_i + 32'd1) : point_y_i;
  assign az = point_z_i[31] ? (~point_z_i + 32'd1) : point_z_i;

  // divider valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j <= DIV_STAGES; j++) fv_q[j] <= 1'b0;
    end else begin
      fv_q[0] <= accept;
      for (int j = 1; j <= DIV_STAGES; j++) fv_q[j] <= fv_q[j-1];
    end
  end

  // divider data: x and y over |z|, dividend shifted up by 30
  always_ff @(posedge clk_i) begin
    dv_q[0].lx.rem <= '0;
    dv_q[0].lx.nq  <= {ax, 30'd0};
    dv_q[0].ly.rem <= '0;
    dv_q[0].ly.nq  <= {ay, 30'd0};
    dv_q[0].dsr    <= az;
    dv_q[0].nx     <= point_x_i[31] ^ point_z_i[31];
    dv_q[0].ny     <= point_y_i[31] ^ point_z_i[31];
    dv_q[0].zd     <= (point_z_i == 32'sd0);
    for (int j = 1; j <= DIV_STAGES; j++) begin
      dv_q[j].lx  <= div_step(dv_q[j-1].lx, dv_q[j-1].dsr);
      dv_q[j].ly  <= div_step(dv_q[j-1].ly, dv_q[j-1].dsr);
      dv_q[j].dsr <= dv_q[j-1].dsr;
      dv_q[j].nx  <= dv_q[j-1].nx;
      dv_q[j].ny  <= dv_q[j-1].ny;
      dv_q[j].zd  <= dv_q[j-1].zd;
    end
  end

  // signed normalized coordinates
  assign qx = fx_t'({{(64-QUO_W){1'b0}}, dv_q[DIV_STAGES].lx.nq});
  assign qy = fx_t'({{(64-QUO_W){1'b0}}, dv_q[DIV_STAGES].ly.nq});

  always_ff @(posedge clk_i) begin
    xn_q <= dv_q[DIV_STAGES].nx ? -qx : qx;
    yn_q <= dv_q[DIV_STAGES].ny ? -qy : qy;
  end

  // squares and cross term
  ppd_mul u_m_xx   (.clk_i, .a_i(xn_q), .b_i(xn_q), .p_o(xx_p),   .ov_o(xx_ov));
  ppd_mul u_m_yy   (.clk_i, .a_i(yn_q), .b_i(yn_q), .p_o(yy_p),   .ov_o(yy_ov));
  ppd_mul u_m_xy   (.clk_i, .a_i(xn_q), .b_i(yn_q), .p_o(xy_p),   .ov_o(xy_ov));
  // tangential terms on the cross product
  ppd_mul u_m_p1xy (.clk_i, .a_i(p1),   .b_i(xy_p), .p_o(p1xy_p), .ov_o(p1xy_ov));
  ppd_mul u_m_p2xy (.clk_i, .a_i(p2),   .b_i(xy_p), .p_o(p2xy_p), .ov_o(p2xy_ov));
  // radius powers and radial terms
  ppd_mul u_m_r4   (.clk_i, .a_i(r2_q), .b_i(r2_q), .p_o(r4_p),   .ov_o(r4_ov));
  ppd_mul u_m_k1   (.clk_i, .a_i(k1),   .b_i(r2_q), .p_o(k1r2_p), .ov_o(k1r2_ov));
  ppd_mul u_m_r6   (.clk_i, .a_i(r4_p), .b_i(r2_dl_q[DL_R2-1]), .p_o(r6_p), .ov_o(r6_ov));
  ppd_mul u_m_k2   (.clk_i, .a_i(k2),   .b_i(r4_p), .p_o(k2r4_p), .ov_o(k2r4_ov));
  ppd_mul u_m_k3   (.clk_i, .a_i(k3),   .b_i(r6_p), .p_o(k3r6_p), .ov_o(k3r6_ov));
  // tangential terms on r2 plus twice the square
  ppd_mul u_m_p2tx (.clk_i, .a_i(p2),   .b_i(tx_q), .p_o(p2tx_p), .ov_o(p2tx_ov));
  ppd_mul u_m_p1ty (.clk_i, .a_i(p1),   .b_i(ty_q), .p_o(p1ty_p), .ov_o(p1ty_ov));
  // radial factor applied
  ppd_mul u_m_xnd  (.clk_i, .a_i(xn_dl_q[DL_XN-1]), .b_i(d_q), .p_o(xnd_p), .ov_o(xnd_ov));
  ppd_mul u_m_ynd  (.clk_i, .a_i(yn_dl_q[DL_XN-1]), .b_i(d_q), .p_o(ynd_p), .ov_o(ynd_ov));
  // focal scaling
  ppd_mul u_m_u    (.clk_i, .a_i(fxe),  .b_i(xd_q), .p_o(u_p),    .ov_o(u_ov));
  ppd_mul u_m_v    (.clk_i, .a_i(fye),  .b_i(yd_q), .p_o(v_p),    .ov_o(v_ov));

  // saturating sums
  assign r2_s   = sat_add(xx_p, yy_p);
  assign xx2_s  = sat_add(xx_p, xx_p);
  assign yy2_s  = sat_add(yy_p, yy_p);
  assign tx_s   = sat_add(r2_q, xx2_q);
  assign ty_s   = sat_add(r2_q, yy2_q);
  assign xyt1_s = sat_add(p1xy_p, p1xy_p);
  assign xyt2_s = sat_add(p2xy_p, p2xy_p);
  assign d1_s   = sat_add(ONE_Q30, k1r2_p);
  assign d2_s   = sat_add(d1_dl_q[DL_D1-1], k2r4_p);
  assign d_s    = sat_add(d2_dl_q[DL_D2-1], k3r6_p);
  assign xe1_s  = sat_add(xnd_p, xyt1_dl_q[DL_XYT1-1]);
  assign ye1_s  = sat_add(ynd_p, p1ty_dl_q[DL_P1TY-1]);
  assign xd_s   = sat_add(xe1_q, p2tx_dl_q[DL_P2TX-1]);
  assign yd_s   = sat_add(ye1_q, xyt2_dl_q[DL_XYT2-1]);

  always_ff @(posedge clk_i) begin
    r2_q   <= r2_s.val;
    xx2_q  <= xx2_s.val;
    yy2_q  <= yy2_s.val;
    tx_q   <= tx_s.val;
    ty_q   <= ty_s.val;
    xyt1_q <= xyt1_s.val;
    xyt2_q <= xyt2_s.val;
    d1_q   <= d1_s.val;
    d2_q   <= d2_s.val;
    d_q    <= d_s.val;
    xe1_q  <= xe1_s.val;
    ye1_q  <= ye1_s.val;
    xd_q   <= xd_s.val;
    yd_q   <= yd_s.val;
  end

  // delay lines aligning operands
  always_ff @(posedge clk_i) begin
    r2_dl_q[0]   <= r2_q;
    xn_dl_q[0]   <= xn_q;
    yn_dl_q[0]   <= yn_q;
    d1_dl_q[0]   <= d1_q;
    d2_dl_q[0]   <= d2_q;
    xyt1_dl_q[0] <= xyt1_q;
    p1ty_dl_q[0] <= p1ty_p;
    p2tx_dl_q[0] <= p2tx_p;
    xyt2_dl_q[0] <= xyt2_q;
    for (int i = 1; i < DL_R2; i++)   r2_dl_q[i]   <= r2_dl_q[i-1];
    for (int i = 1; i < DL_XN; i++)   xn_dl_q[i]   <= xn_dl_q[i-1];
    for (int i = 1; i < DL_XN; i++)   yn_dl_q[i]   <= yn_dl_q[i-1];
    for (int i = 1; i < DL_D1; i++)   d1_dl_q[i]   <= d1_dl_q[i-1];
    for (int i = 1; i < DL_D2; i++)   d2_dl_q[i]   <= d2_dl_q[i-1];
    for (int i = 1; i < DL_XYT1; i++) xyt1_dl_q[i] <= xyt1_dl_q[i-1];
    for (int i = 1; i < DL_P1TY; i++) p1ty_dl_q[i] <= p1ty_dl_q[i-1];
    for (int i = 1; i < DL_P2TX; i++) p2tx_dl_q[i] <= p2tx_dl_q[i-1];
    for (int i = 1; i < DL_XYT2; i++) xyt2_dl_q[i] <= xyt2_dl_q[i-1];
  end

  // overflow seen at each stage
  always_comb begin
    hit = '0;
    hit[S_XX]  = hit[S_XX]  | xx_ov | yy_ov | xy_ov | r2_s.ov | xx2_s.ov | yy2_s.ov;
    hit[S_R2]  = hit[S_R2]  | tx_s.ov | ty_s.ov;
    hit[S_PXY] = hit[S_PXY] | p1xy_ov | p2xy_ov | xyt1_s.ov | xyt2_s.ov;
    hit[S_R4]  = hit[S_R4]  | r4_ov | k1r2_ov | d1_s.ov;
    hit[S_PT]  = hit[S_PT]  | p2tx_ov | p1ty_ov;
    hit[S_R6]  = hit[S_R6]  | r6_ov | k2r4_ov | d2_s.ov;
    hit[S_K3]  = hit[S_K3]  | k3r6_ov | d_s.ov;
    hit[S_ND]  = hit[S_ND]  | xnd_ov | ynd_ov | xe1_s.ov | ye1_s.ov;
    hit[S_E1]  = hit[S_E1]  | xd_s.ov | yd_s.ov;
    hit[S_UV]  = hit[S_UV]  | u_ov | v_ov;
  end

  // back end valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= S_UV; s++) vld_q[s] <= 1'b0;
      done_q <= 1'b0;
    end else begin
      vld_q[0] <= fv_q[DIV_STAGES];
      for (int s = 1; s <= S_UV; s++) vld_q[s] <= vld_q[s-1];
      done_q <= vld_q[S_UV];
    end
  end

  // zero depth and overflow flags ride with the data
  always_ff @(posedge clk_i) begin
    zd_q[0] <= dv_q[DIV_STAGES].zd;
    ov_q[0] <= 1'b0;
    for (int s = 1; s <= S_UV; s++) begin
      zd_q[s] <= zd_q[s-1];
      ov_q[s] <= ov_q[s-1] | hit[s-1];
    end
  end

  // principal point and 32 bit clamp
  always_comb begin
    pu     = u_p + fx_t'({32'd0, pp_q[31:0]});
    pv     = v_p + fx_t'({32'd0, pp_q[63:32]});
    ovu    = 1'b0;
    ovv    = 1'b0;
    pu_sat = pu[31:0];
    pv_sat = pv[31:0];
    if (pu > 64'sd2147483647) begin
      pu_sat = 32'sh7FFF_FFFF;
      ovu    = 1'b1;
    end else if (pu < -64'sd2147483648) begin
      pu_sat = 32'sh8000_0000;
      ovu    = 1'b1;
    end
    if (pv > 64'sd2147483647) begin
      pv_sat = 32'sh7FFF_FFFF;
      ovv    = 1'b1;
    end else if (pv < -64'sd2147483648) begin
      pv_sat = 32'sh8000_0000;
      ovv    = 1'b1;
    end
    ov_fin = ov_q[S_UV] | hit[S_UV] | ovu | ovv;
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (zd_q[S_UV]) begin
      pixel_u_q <= '0;
      pixel_v_q <= '0;
      status_q  <= ST_ZERO_DEPTH;
    end else begin
      pixel_u_q <= pu_sat;
      pixel_v_q <= pv_sat;
      status_q  <= ov_fin ? ST_SATURATED : ST_OK;
    end
  end

  assign done_o    = done_q;
  assign pixel_u_o = pixel_u_q;
  assign pixel_v_o = pixel_v_q;
  assign status_o  = status_q;

endmodule

// File: hw/rtl/ppd_mul.sv
// ----------------------------------------------------------------------------
// ppd_mul
// Pipelined signed multiply, product shifted down by 30 and clamped.
// Steps in order: partial products, product sum, scale and clamp.
// ----------------------------------------------------------------------------
module ppd_mul (
  input  logic          clk_i,
  input  ppd_pkg::fx_t  a_i,
  input  ppd_pkg::fx_t  b_i,
  output ppd_pkg::fx_t  p_o,
  output logic          ov_o
);
  import ppd_pkg::*;

  localparam int unsigned HW = 31;
  localparam int unsigned PW = 2 * HW;
  localparam int unsigned FW = 2 * PW;

  logic [63:0]   ma, mb;
  logic [PW-1:0] pp00_q, pp01_q, pp10_q, pp11_q;
  logic          neg1_q, neg2_q;
  logic [FW-1:0] prod_q;
  fx_t           q;
  logic          ov;
  fx_t           p_q;
  logic          ov_q;

  // magnitudes, operands stay within 62 bits
  assign ma = a_i[63] ? (~a_i + 64'd1) : a_i;
  assign mb = b_i[63] ? (~b_i + 64'd1) : b_i;

  // partial products on 31 bit halves
  always_ff @(posedge clk_i) begin
    pp00_q <= PW'(ma[HW-1:0]) * PW'(mb[HW-1:0]);
    pp01_q <= PW'(ma[HW-1:0]) * PW'(mb[PW-1:HW]);
    pp10_q <= PW'(ma[PW-1:HW]) * PW'(mb[HW-1:0]);
    pp11_q <= PW'(ma[PW-1:HW]) * PW'(mb[PW-1:HW]);
    neg1_q <= a_i[63] ^ b_i[63];
  end

  // full product
  always_ff @(posedge clk_i) begin
    prod_q <= FW'(pp00_q) + ((FW'(pp01_q) + FW'(pp10_q)) << HW) + (FW'(pp11_q) << PW);
    neg2_q <= neg1_q;
  end

  // scale, clamp, sign
  always_comb begin
    ov = |prod_q[FW-1:92];
    q  = ov ? LIM : fx_t'({2'b00, prod_q[91:30]});
  end

  always_ff @(posedge clk_i) begin
    p_q  <= neg2_q ? -q : q;
    ov_q <= ov;
  end

  assign p_o  = p_q;
  assign ov_o = ov_q;

endmodule

// File: hw/rtl/ppd_checker.sv
// ----------------------------------------------------------------------------
// ppd_checker
// Port-level checks on result timing and zero-depth results.
// ----------------------------------------------------------------------------
module ppd_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic signed [31:0] point_z_i,
  input logic               done_o,
  input logic signed [31:0] pixel_u_o,
  input logic signed [31:0] pixel_v_o,
  input logic [1:0]         status_o
);
  import ppd_pkg::*;

  // every accepted point gives a result after the fixed latency
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LATENCY done_o)
    else $error("result missing after fixed latency");

  // a zero depth point comes back flagged
  a_zero_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && point_z_i == 32'sd0) |-> ##LATENCY (status_o == ST_ZERO_DEPTH))
    else $error("zero depth not flagged");

  // zero depth results carry a zero pixel
  a_zero_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_ZERO_DEPTH) |-> (pixel_u_o == 32'sd0 && pixel_v_o == 32'sd0))
    else $error("zero depth result with nonzero pixel");

endmodule

bind pinhole_projection_with_distortion ppd_checker u_ppd_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .start     (start),
  .busy      (busy),
  .point_z_i (point_z_i),
  .done_o    (done_o),
  .pixel_u_o (pixel_u_o),
  .pixel_v_o (pixel_v_o),
  .status_o  (status_o)
);
